[design/qrv_pkg.sv]
`timescale 1ns / 1ps
// qrv_pkg: types and constants for the quaternion vector rotation block.
// No dependencies; used by qrv_matrix and quaternion_rotate_vector_top.
package qrv_pkg;

	localparam int QW      = 16;   // quaternion component, Q2.14
	localparam int QPROD_W = 32;   // product of two components
	localparam int MAT_W   = 35;   // matrix element, Q4.28 plus headroom
	localparam int EXT_W   = 48;   // vector coordinate, widest supported
	localparam int LIMB    = 24;   // split point of a coordinate
	localparam int HI_W    = EXT_W - LIMB;
	localparam int LO_W    = LIMB + 1;  // low limb plus a zero sign bit
	localparam int PROD_W  = MAT_W + LO_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int SUM_W   = ACC_W + LIMB;
	localparam int FRAC_SH = 28;   // Q.44 product down to Q.16
	localparam int RES_W   = SUM_W - FRAC_SH;

	localparam logic signed [QW-1:0] QUAT_ONE = 16'sd16384;

	typedef enum logic [1:0] {
		REG_QUAT_I    = 2'd0,
		REG_QUAT_J    = 2'd1,
		REG_QUAT_K    = 2'd2,
		REG_QUAT_REAL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] a;
		logic signed [QW-1:0] b;
		logic signed [QW-1:0] c;
	} quat_t;

	typedef logic signed [MAT_W-1:0] mel_t;
	typedef mel_t mat_t [3][3];

endpackage

[design/qrv_matrix.sv]
`timescale 1ns / 1ps
// qrv_matrix: rotation matrix M (Q4.28) from the configured quaternion.
// Two register stages: component products, then sums. Uses qrv_pkg.
module qrv_matrix (
	input  logic           clk,
	input  qrv_pkg::quat_t quat,
	output qrv_pkg::mat_t  mat
);

	localparam int PW = qrv_pkg::QPROD_W;
	localparam int MW = qrv_pkg::MAT_W;

	logic signed [PW-1:0] ww_q, aa_q, bb_q, cc_q;
	logic signed [PW-1:0] ab_q, ac_q, bc_q, wa_q, wb_q, wc_q;
	qrv_pkg::mat_t        mat_q;

	always_ff @(posedge clk) begin
		ww_q <= PW'(quat.w) * PW'(quat.w);
		aa_q <= PW'(quat.a) * PW'(quat.a);
		bb_q <= PW'(quat.b) * PW'(quat.b);
		cc_q <= PW'(quat.c) * PW'(quat.c);
		ab_q <= PW'(quat.a) * PW'(quat.b);
		ac_q <= PW'(quat.a) * PW'(quat.c);
		bc_q <= PW'(quat.b) * PW'(quat.c);
		wa_q <= PW'(quat.w) * PW'(quat.a);
		wb_q <= PW'(quat.w) * PW'(quat.b);
		wc_q <= PW'(quat.w) * PW'(quat.c);
	end

	always_ff @(posedge clk) begin
		mat_q[0][0] <= MW'(ww_q) + MW'(aa_q) - MW'(bb_q) - MW'(cc_q);
		mat_q[0][1] <= (MW'(ab_q) - MW'(wc_q)) <<< 1;
		mat_q[0][2] <= (MW'(ac_q) + MW'(wb_q)) <<< 1;
		mat_q[1][0] <= (MW'(ab_q) + MW'(wc_q)) <<< 1;
		mat_q[1][1] <= MW'(ww_q) - MW'(aa_q) + MW'(bb_q) - MW'(cc_q);
		mat_q[1][2] <= (MW'(bc_q) - MW'(wa_q)) <<< 1;
		mat_q[2][0] <= (MW'(ac_q) - MW'(wb_q)) <<< 1;
		mat_q[2][1] <= (MW'(bc_q) + MW'(wa_q)) <<< 1;
		mat_q[2][2] <= MW'(ww_q) - MW'(aa_q) - MW'(bb_q) + MW'(cc_q);
	end

	assign mat = mat_q;

endmodule

[design/quaternion_rotate_vector_top.sv]
`timescale 1ns / 1ps
// Quaternion vector rotation: rot = vector part of q * (v,0) * conj(q), Q16.16, saturated.
// Throughput one word per cycle while rot_stall is low.
// Six pipeline stages: capture, limb split, 18 matrix-limb multipliers, row sums,
// limb merge and rounding, saturation. After a register write the matrix is rebuilt
// through the product and sum registers of qrv_matrix, covered by the first two stages.
// Reset clears stage valids and sets q to identity. Depends on qrv_pkg and qrv_matrix.
module quaternion_rotate_vector_top #(
	parameter int VEC_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB-style register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// vector input
	input  logic                        vec_valid,
	output logic                        vec_stall,
	input  logic signed [VEC_WIDTH-1:0] vec_x,
	input  logic signed [VEC_WIDTH-1:0] vec_y,
	input  logic signed [VEC_WIDTH-1:0] vec_z,
	// rotated output
	output logic                        rot_valid,
	input  logic                        rot_stall,
	output logic signed [VEC_WIDTH-1:0] rot_x,
	output logic signed [VEC_WIDTH-1:0] rot_y,
	output logic signed [VEC_WIDTH-1:0] rot_z,
	output logic                        saturated
);

	localparam int EXT_W   = qrv_pkg::EXT_W;
	localparam int LIMB    = qrv_pkg::LIMB;
	localparam int HI_W    = qrv_pkg::HI_W;
	localparam int LO_W    = qrv_pkg::LO_W;
	localparam int PROD_W  = qrv_pkg::PROD_W;
	localparam int ACC_W   = qrv_pkg::ACC_W;
	localparam int SUM_W   = qrv_pkg::SUM_W;
	localparam int FRAC_SH = qrv_pkg::FRAC_SH;
	localparam int RES_W   = qrv_pkg::RES_W;

	localparam logic signed [VEC_WIDTH-1:0] OUT_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic signed [VEC_WIDTH-1:0] OUT_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};
	localparam logic signed [RES_W-1:0]     SAT_HI  = RES_W'(OUT_MAX);
	localparam logic signed [RES_W-1:0]     SAT_LO  = RES_W'(OUT_MIN);
	// one half of the Q.16 LSB at the Q.44 weight of the low-limb sum
	localparam logic signed [ACC_W-1:0]     HALF    = ACC_W'(1) <<< (FRAC_SH - 1);

	// ---------------- configuration registers ----------------
	qrv_pkg::quat_t    quat_q;
	qrv_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	assign reg_idx = qrv_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.a <= '0;
			quat_q.b <= '0;
			quat_q.c <= '0;
			quat_q.w <= qrv_pkg::QUAT_ONE;
		end else if (cfg_wr) begin
			case (reg_idx)
				qrv_pkg::REG_QUAT_I:    quat_q.a <= pwdata[15:0];
				qrv_pkg::REG_QUAT_J:    quat_q.b <= pwdata[15:0];
				qrv_pkg::REG_QUAT_K:    quat_q.c <= pwdata[15:0];
				qrv_pkg::REG_QUAT_REAL: quat_q.w <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			qrv_pkg::REG_QUAT_I:    prdata = {16'd0, quat_q.a};
			qrv_pkg::REG_QUAT_J:    prdata = {16'd0, quat_q.b};
			qrv_pkg::REG_QUAT_K:    prdata = {16'd0, quat_q.c};
			qrv_pkg::REG_QUAT_REAL: prdata = {16'd0, quat_q.w};
			default:                prdata = '0;
		endcase
	end

	qrv_pkg::mat_t mat;

	qrv_matrix u_matrix (
		.clk  (clk),
		.quat (quat_q),
		.mat  (mat)
	);

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || !rot_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign vec_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vec_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ---------------- datapath ----------------
	logic signed [EXT_W-1:0]  vec_s1 [3];
	logic signed [HI_W-1:0]   hi_s2  [3];
	logic signed [LO_W-1:0]   lo_s2  [3];
	logic signed [PROD_W-1:0] phi_s3 [3][3];
	logic signed [PROD_W-1:0] plo_s3 [3][3];
	logic signed [ACC_W-1:0]  ahi_s4 [3];
	logic signed [ACC_W-1:0]  alo_s4 [3];
	logic signed [RES_W-1:0]  res_s5 [3];
	logic signed [VEC_WIDTH-1:0] rot_s6 [3];
	logic                     sat_s6;
	logic signed [SUM_W-1:0]  tot    [3];
	logic [2:0]               clip_hi, clip_lo;

	// stage 1: capture and sign-extend
	always_ff @(posedge clk) begin
		if (en1 && vec_valid) begin
			vec_s1[0] <= EXT_W'(vec_x);
			vec_s1[1] <= EXT_W'(vec_y);
			vec_s1[2] <= EXT_W'(vec_z);
		end
	end

	// stage 2: v = hi * 2^24 + lo, lo non-negative
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int j = 0; j < 3; j++) begin
				hi_s2[j] <= vec_s1[j][EXT_W-1:LIMB];
				lo_s2[j] <= {1'b0, vec_s1[j][LIMB-1:0]};
			end
		end
	end

	// stage 3: matrix times each limb
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					phi_s3[r][j] <= PROD_W'(mat[r][j]) * PROD_W'(hi_s2[j]);
					plo_s3[r][j] <= PROD_W'(mat[r][j]) * PROD_W'(lo_s2[j]);
				end
			end
		end
	end

	// stage 4: row sums, rounding half folded into the low sum
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int r = 0; r < 3; r++) begin
				ahi_s4[r] <= ACC_W'(phi_s3[r][0]) + ACC_W'(phi_s3[r][1])
					+ ACC_W'(phi_s3[r][2]);
				alo_s4[r] <= ACC_W'(plo_s3[r][0]) + ACC_W'(plo_s3[r][1])
					+ ACC_W'(plo_s3[r][2]) + HALF;
			end
		end
	end

	// stage 5: merge limbs, floor to Q.16
	always_comb begin
		for (int r = 0; r < 3; r++)
			tot[r] = (SUM_W'(ahi_s4[r]) <<< LIMB) + SUM_W'(alo_s4[r]);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int r = 0; r < 3; r++)
				res_s5[r] <= tot[r][SUM_W-1:FRAC_SH];
		end
	end

	// stage 6: saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			clip_hi[r] = res_s5[r] > SAT_HI;
			clip_lo[r] = res_s5[r] < SAT_LO;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int r = 0; r < 3; r++) begin
				if (clip_hi[r])
					rot_s6[r] <= OUT_MAX;
				else if (clip_lo[r])
					rot_s6[r] <= OUT_MIN;
				else
					rot_s6[r] <= res_s5[r][VEC_WIDTH-1:0];
			end
			sat_s6 <= |{clip_hi, clip_lo};
		end
	end

	assign rot_valid = v_s6;
	assign rot_x     = rot_s6[0];
	assign rot_y     = rot_s6[1];
	assign rot_z     = rot_s6[2];
	assign saturated = sat_s6;

`ifndef SYNTHESIS
	// input is only held off when the capture stage is full and blocked
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> (v_s1 && !en2))
		else $error("vec_stall raised with room in stage 1");

	// an accepted word lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_valid && !vec_stall) |=> v_s1)
		else $error("accepted word lost at stage 1");

	// a word leaving stage 5 reaches the output register
	a_no_drop_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en6) |=> rot_valid)
		else $error("word lost between stage 5 and output");

	// a saturation flag means some coordinate sits on a bound
	a_sat_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && saturated) |->
			(rot_x == OUT_MAX || rot_x == OUT_MIN || rot_y == OUT_MAX ||
			 rot_y == OUT_MIN || rot_z == OUT_MAX || rot_z == OUT_MIN))
		else $error("saturated set with no coordinate at a bound");
`endif

endmodule

[dv/tb_quaternion_rotate_vector_top.sv]
`timescale 1ns / 1ps
// Testbench for quaternion_rotate_vector_top: random and directed vectors under several q settings,
// each result checked against a local wide-integer rotation predictor held in a scoreboard class.
// Depends on qrv_pkg and quaternion_rotate_vector_top.
module tb_quaternion_rotate_vector_top;

	localparam int VW         = 32;
	localparam int IDLE_LIMIT = 5000;
	localparam int N_PHASES   = 10;
	localparam int RAND_ITEMS = 90;

	typedef logic signed [79:0] wide_t;
	localparam wide_t ROT_MAX = (80'sd1 <<< (VW - 1)) - 80'sd1;
	localparam wide_t ROT_MIN = -(80'sd1 <<< (VW - 1));
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 sat;
	} rot_word_t;

	class rotation_scoreboard;
		logic signed [15:0] qa, qb, qc, qw;
		rot_word_t expected_rot[$];
		int errors;

		function new();
			qa = '0;
			qb = '0;
			qc = '0;
			qw = qrv_pkg::QUAT_ONE;
			errors = 0;
		endfunction

		function void set_quat(qrv_pkg::reg_idx_t idx, logic [15:0] val);
			case (idx)
				qrv_pkg::REG_QUAT_I:    qa = val;
				qrv_pkg::REG_QUAT_J:    qb = val;
				qrv_pkg::REG_QUAT_K:    qc = val;
				qrv_pkg::REG_QUAT_REAL: qw = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_rot.size();
		endfunction

		// exact M*v in 80 bits, plus half LSB, floor to Q.16, then clip
		function void note_vec(logic signed [VW-1:0] x, logic signed [VW-1:0] y,
				logic signed [VW-1:0] z);
			wide_t a, b, c, w, acc;
			wide_t m [3][3];
			wide_t v [3];
			wide_t res [3];
			rot_word_t e;
			a = qa;
			b = qb;
			c = qc;
			w = qw;
			v[0] = x;
			v[1] = y;
			v[2] = z;
			m[0][0] = w*w + a*a - b*b - c*c;
			m[0][1] = 2 * (a*b - w*c);
			m[0][2] = 2 * (a*c + w*b);
			m[1][0] = 2 * (a*b + w*c);
			m[1][1] = w*w - a*a + b*b - c*c;
			m[1][2] = 2 * (b*c - w*a);
			m[2][0] = 2 * (a*c - w*b);
			m[2][1] = 2 * (b*c + w*a);
			m[2][2] = w*w - a*a - b*b + c*c;
			e.sat = 1'b0;
			for (int r = 0; r < 3; r++) begin
				acc = 80'sd1 <<< 27;
				for (int j = 0; j < 3; j++)
					acc += m[r][j] * v[j];
				res[r] = acc >>> 28;
				if (res[r] > ROT_MAX) begin
					res[r] = ROT_MAX;
					e.sat = 1'b1;
				end
				if (res[r] < ROT_MIN) begin
					res[r] = ROT_MIN;
					e.sat = 1'b1;
				end
			end
			e.x = res[0][VW-1:0];
			e.y = res[1][VW-1:0];
			e.z = res[2][VW-1:0];
			expected_rot.push_back(e);
		endfunction

		function void report(string field, longint exp_v, longint act_v);
			errors++;
			$error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
		endfunction

		function void check_rot(rot_word_t act);
			rot_word_t e;
			if (expected_rot.size() == 0) begin
				errors++;
				$error("rotated word with nothing expected: x=%0d y=%0d z=%0d",
					act.x, act.y, act.z);
				return;
			end
			e = expected_rot.pop_front();
			if (act.x !== e.x)     report("rot_x", e.x, act.x);
			if (act.y !== e.y)     report("rot_y", e.y, act.y);
			if (act.z !== e.z)     report("rot_z", e.z, act.z);
			if (act.sat !== e.sat) report("saturated", e.sat, act.sat);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic vec_valid, vec_stall;
	logic signed [VW-1:0] vec_x, vec_y, vec_z;
	logic rot_valid, rot_stall;
	logic signed [VW-1:0] rot_x, rot_y, rot_z;
	logic saturated;

	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	rotation_scoreboard sb;

	quaternion_rotate_vector_top #(.VEC_WIDTH(VW)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.vec_valid(vec_valid), .vec_stall(vec_stall),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.rot_valid(rot_valid), .rot_stall(rot_stall),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .saturated(saturated)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rot_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// monitors see pre-edge values: all inputs are driven with NBAs
	always @(posedge clk) begin
		if (arst_n && vec_valid && !vec_stall)
			sb.note_vec(vec_x, vec_y, vec_z);
		if (arst_n && rot_valid && !rot_stall)
			sb.check_rot('{rot_x, rot_y, rot_z, saturated});
	end

	always @(posedge clk) begin
		if ((vec_valid && !vec_stall) || (rot_valid && !rot_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_quaternion_rotate_vector_top failed");
			$finish;
		end
	end

	// setup then access; psel stays high across back-to-back writes
	task automatic apb_write(qrv_pkg::reg_idx_t idx, logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_quat(idx, val);
	endtask

	task automatic load_quat(qrv_pkg::quat_t q);
		apb_write(qrv_pkg::REG_QUAT_I, q.a);
		apb_write(qrv_pkg::REG_QUAT_J, q.b);
		apb_write(qrv_pkg::REG_QUAT_K, q.c);
		apb_write(qrv_pkg::REG_QUAT_REAL, q.w);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_vec(logic signed [VW-1:0] x, logic signed [VW-1:0] y,
			logic signed [VW-1:0] z);
		while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do @(posedge clk); while (vec_stall);
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [VW-1:0] rand_coord();
		logic signed [VW-1:0] v;
		v = $urandom;
		case ($urandom_range(9))
			5, 6: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			7: begin
				case ($urandom_range(4))
					0: v = VMAX;
					1: v = VMIN;
					2: v = '0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			// near the rounding half point when q is tiny
			8: v = ($urandom_range(1) ? 1 : -1) * (32'sd1 <<< 27) + $signed($urandom_range(0, 4)) - 2;
			9: v = v >>> $urandom_range(0, 24);
			default: ;
		endcase
		return v;
	endfunction

	function automatic qrv_pkg::quat_t phase_quat(int p);
		qrv_pkg::quat_t q;
		q = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
		case (p)
			1: q = '{w: 16'sd11585, a: 16'sd0, b: 16'sd0, c: 16'sd11585};
			2: q = '{w: 16'sd0, a: 16'sd1, b: 16'sd0, c: 16'sd0};
			3: q = '{w: 16'sh7fff, a: 16'sh7fff, b: 16'sh7fff, c: 16'sh7fff};
			4: q = '{w: 16'sh8000, a: 16'sh8000, b: 16'sh8000, c: 16'sh8000};
			5: q = '0;
			6: q = '{w: 16'sh8000, a: 16'sh7fff, b: 16'sh8000, c: 16'sh7fff};
			7: q = '{w: 16'sd9459, a: 16'sd9459, b: 16'sd9459, c: 16'sd9459};
			default: ;
		endcase
		return q;
	endfunction

	initial begin
		sb = new();
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		vec_valid <= 1'b0;
		vec_x     <= '0;
		vec_y     <= '0;
		vec_z     <= '0;
		rot_stall <= 1'b0;
		idle_pct  = 18;
		stall_pct = 18;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			// phase 0 runs on the reset identity; others reprogram q while idle
			if (p != 0) begin
				drain();
				load_quat(phase_quat(p));
			end
			// one phase with both sides streaming flat out
			idle_pct  = (p == 1) ? 0 : 18;
			stall_pct = (p == 1) ? 0 : 18;
			case (p)
				0: begin
					push_vec('0, '0, '0);
					push_vec(VMAX, VMAX, VMAX);
					push_vec(VMIN, VMIN, VMIN);
					push_vec(VMAX, VMIN, 1);
					push_vec(-1, 1, -1);
					push_vec(32'sh0100_0000, -32'sh0100_0000, 32'sh00ff_ffff);
					push_vec(32'sh00ff_ffff, 32'shff00_0000, 32'sh5555_aaaa);
				end
				2: begin
					// ties round toward plus infinity
					push_vec(32'sd1 <<< 27, '0, '0);
					push_vec(-(32'sd1 <<< 27), '0, '0);
					push_vec((32'sd1 <<< 27) - 1, VMAX, VMIN);
					push_vec(-(32'sd1 <<< 27) - 1, '0, '0);
					push_vec(32'sd3 <<< 27, -(32'sd3 <<< 27), '0);
				end
				3: begin
					push_vec(VMAX, VMAX, VMAX);
					push_vec(VMIN, VMIN, VMIN);
					push_vec(VMAX, VMIN, VMAX);
				end
				default: ;
			endcase
			for (int n = 0; n < RAND_ITEMS; n++)
				push_vec(rand_coord(), rand_coord(), rand_coord());
			vec_valid <= 1'b0;
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_quaternion_rotate_vector_top passed");
		else
			$display("tb_quaternion_rotate_vector_top failed");
		$finish;
	end

endmodule
